/* hdl/assert_macros.svh */
// Assertion macros used by the list core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("list assertion failed");

`endif

/* hdl/plk_pkg.sv */
// Types and constants of the indexed priority list.
package plk_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_LOWER  = 3'd3,
        KIND_RAISE  = 3'd4,
        KIND_LAST   = 3'd5,
        KIND_TOP    = 3'd6
    } t_plk_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_plk_status;

    // Operation broadcast to every cell.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_LOWER,
        OP_RAISE,
        OP_LAST,
        OP_TOP
    } t_plk_op;

    typedef struct packed {
        t_plk_op           op;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  last;
        logic [DATA_W-1:0] data;
    } t_plk_cmd;

endpackage

/* hdl/plk_in_if.sv */
// Request channel of the list: operation, position and element.
interface plk_in_if;
    logic                      valid;
    logic                      ready;
    logic [plk_pkg::KIND_W-1:0] kind;
    logic [plk_pkg::POS_W-1:0]  position;
    logic [plk_pkg::DATA_W-1:0] element;

    modport source (output valid, kind, position, element, input ready);
    modport sink   (input valid, kind, position, element, output ready);
endinterface

/* hdl/plk_out_if.sv */
// Response channel of the list: read value, status, count and empty flag.
interface plk_out_if;
    logic                       valid;
    logic                       ready;
    logic [plk_pkg::DATA_W-1:0] read_value;
    logic [plk_pkg::STAT_W-1:0] status;
    logic [plk_pkg::POS_W-1:0]  count;
    logic                       empty_res;

    modport source (output valid, read_value, status, count, empty_res, input ready);
    modport sink   (input valid, read_value, status, count, empty_res, output ready);
endinterface

/* hdl/plk_cell.sv */
// One list slot: holds an entry and loads from a neighbor or the broadcast data.
module plk_cell (
    input  logic                       i_clk,
    input  logic [plk_pkg::CNT_W-1:0]  i_index,
    input  plk_pkg::t_plk_cmd          i_cmd,
    input  logic [plk_pkg::DATA_W-1:0] i_left,
    input  logic [plk_pkg::DATA_W-1:0] i_right,
    output logic [plk_pkg::DATA_W-1:0] o_value
);
    import plk_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              w_is_pos;
    logic              w_above;   // index greater than pos
    logic              w_first;

    assign w_is_pos = (i_index == i_cmd.pos);
    assign w_above  = (i_index > i_cmd.pos);
    assign w_first  = (i_index == '0);

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            OP_INSERT: begin
                if (w_is_pos) begin
                    n_value = i_cmd.data;
                end else if (w_above) begin
                    n_value = i_left;
                end
            end
            OP_REMOVE: begin
                if (w_is_pos || w_above) begin
                    n_value = i_right;
                end
            end
            OP_LOWER: begin
                if (w_is_pos) begin
                    n_value = i_right;
                end else if (!w_first && (i_index - 1'b1) == i_cmd.pos) begin
                    n_value = i_left;
                end
            end
            OP_RAISE: begin
                if (w_is_pos) begin
                    n_value = i_left;
                end else if ((i_index + 1'b1) == i_cmd.pos) begin
                    n_value = i_right;
                end
            end
            OP_LAST: begin
                if (i_index == i_cmd.last) begin
                    n_value = i_cmd.data;
                end else if ((w_is_pos || w_above) && i_index < i_cmd.last) begin
                    n_value = i_right;
                end
            end
            OP_TOP: begin
                if (w_first) begin
                    n_value = i_cmd.data;
                end else if (!w_above) begin
                    n_value = i_left;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* hdl/indexed_priority_list_core.sv */
// Top level of the indexed priority list: a row of slot cells plus control.
//
//  channel | dir | payload                                  | accepted when
//  i_in    | in  | kind, position, element                  | valid & ready
//  o_out   | out | read_value, status, count, empty_res     | valid & ready
//
// A request is decoded against the count, every cell loads in parallel from
// a neighbor or the broadcast data (or holds), and the response lands in
// the output register on the same edge. The path is the position mux over
// the cells plus the per-cell compare. Reset (synchronous, active low)
// clears the count and the output valid and holds input ready low; entry
// contents are left as is.
// A stalled response holds its register; a new request is taken in the
// cycle the waiting response is taken.
module indexed_priority_list_core (
    input  logic i_clk,
    input  logic i_rst_n,
    plk_in_if.sink    i_in,
    plk_out_if.source o_out
);
    import plk_pkg::*;

    `include "assert_macros.svh"

    // Control state
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_used;
    logic              r_out_valid;

    // Response payload
    logic [DATA_W-1:0] r_read_value;
    t_plk_status       r_status;
    logic [CNT_W-1:0]  r_count;

    logic              w_accept;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_used;
    logic              w_in_list;
    logic [DATA_W-1:0] w_pick;
    logic [DATA_W-1:0] w_val [CAPACITY];
    t_plk_cmd          w_cmd;
    t_plk_status       n_status;
    logic [DATA_W-1:0] n_read_value;

    // No request is taken while reset is held.
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_pos     = CMP_W'(i_in.position);
    assign w_used    = CMP_W'(r_used);
    assign w_in_list = (w_pos < w_used);
    assign w_pick    = w_in_list ? w_val[IDX_W'(w_pos)] : '0;

    // Decode: status, read data and the command for the cells.
    always_comb begin
        n_status     = ST_OK;
        n_read_value = '0;
        n_used       = r_used;
        w_cmd.op     = OP_HOLD;
        w_cmd.pos    = CNT_W'(w_pos);
        w_cmd.last   = r_used - 1'b1;
        w_cmd.data   = w_pick;
        unique case (t_plk_kind'(i_in.kind))
            KIND_READ: begin
                if (w_in_list) begin
                    n_read_value = w_pick;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            KIND_INSERT: begin
                if (w_pos > w_used) begin
                    n_status = ST_RANGE;
                end else if (w_used >= CMP_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.op   = OP_INSERT;
                    w_cmd.data = i_in.element;
                    n_used     = r_used + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!w_in_list) begin
                    n_status = ST_RANGE;
                end else begin
                    w_cmd.op = OP_REMOVE;
                    n_used   = r_used - 1'b1;
                end
            end
            KIND_LOWER: begin
                if (!w_in_list) begin
                    n_status = ST_RANGE;
                end else if ((w_pos + 1'b1) < w_used) begin
                    w_cmd.op = OP_LOWER;
                end
            end
            KIND_RAISE: begin
                if (!w_in_list) begin
                    n_status = ST_RANGE;
                end else if (w_pos != '0) begin
                    w_cmd.op = OP_RAISE;
                end
            end
            KIND_LAST: begin
                if (!w_in_list) begin
                    n_status = ST_RANGE;
                end else if ((w_pos + 1'b1) < w_used) begin
                    w_cmd.op = OP_LAST;
                end
            end
            KIND_TOP: begin
                if (!w_in_list) begin
                    n_status = ST_RANGE;
                end else if (w_pos != '0) begin
                    w_cmd.op = OP_TOP;
                end
            end
            default: n_status = ST_RANGE;   // unused kind code
        endcase
        if (!w_accept) begin
            w_cmd.op = OP_HOLD;
            n_used   = r_used;
        end
    end

    // Row of cells; the end cells see zero beyond the row.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_next
            assign w_right = w_val[g+1];
        end
        plk_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CNT_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_count      <= n_used;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_read_value;
    assign o_out.status     = r_status;
    assign o_out.count      = POS_W'(r_count);
    assign o_out.empty_res  = (r_count == '0);

    // Count never passes the slot count.
    `PLK_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(CAPACITY))
    // Refused requests leave the count alone.
    `PLK_ASSERT_NEXT(a_refused_hold, i_clk, i_rst_n, w_accept && n_status != ST_OK, r_used == $past(r_used))
    // Successful insert grows the list by one.
    `PLK_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n, w_cmd.op == OP_INSERT, r_used == $past(r_used) + 1'b1)
    // Successful remove shrinks the list by one.
    `PLK_ASSERT_NEXT(a_remove_shrink, i_clk, i_rst_n, w_cmd.op == OP_REMOVE, r_used == $past(r_used) - 1'b1)

endmodule
